// File: rtl/core/rv32sc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rv32sc_pkg
// Opcodes, function codes and the per-instruction result record shared by
// the RV32I subset core.
// ----------------------------------------------------------------------------
package rv32sc_pkg;

   localparam int DATA_WORDS_DEFAULT = 32;

   localparam logic [6:0] OPC_RTYPE  = 7'b0110011;
   localparam logic [6:0] OPC_ITYPE  = 7'b0010011;
   localparam logic [6:0] OPC_LOAD   = 7'b0000011;
   localparam logic [6:0] OPC_STORE  = 7'b0100011;
   localparam logic [6:0] OPC_BRANCH = 7'b1100011;

   localparam logic [2:0] F3_ADD  = 3'b000;
   localparam logic [2:0] F3_OR   = 3'b110;
   localparam logic [2:0] F3_AND  = 3'b111;
   localparam logic [2:0] F3_WORD = 3'b010;
   localparam logic [2:0] F3_BEQ  = 3'b000;

   localparam logic [6:0] F7_BASE = 7'b0000000;
   localparam logic [6:0] F7_ALT  = 7'b0100000;

   // One instruction's outcome as it moves down the pipe
   typedef struct packed {
      logic [31:0] next_pc;
      logic        executed;
      logic        branch_taken;
      logic        reg_written;
      logic [4:0]  dest_index;
      logic [31:0] dest_value;
      logic        is_load;
      logic        store_done;
      logic [31:0] store_value;
   } res_type;

endpackage
`default_nettype wire

// File: rtl/core/rv32_subset_single_cycle_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one instruction per cycle while rsp_ready allows; a register read of
// a load's destination within the next three instructions stalls the execute stage.
// Reset: a clearing pass over max(DATA_WORDS, 32) words zeroes register file and
// data memory; no request is accepted during it. The PC resets to 0.
// ----------------------------------------------------------------------------
// rv32_subset_single_cycle_core
// RV32I subset (add sub or and addi ori andi lw sw beq). Register file and
// data memory are synchronous RAMs; pipe: execute, two word-index stages,
// memory access, response register. Operands are forwarded from all later stages
// (loads only from the response stage) and from writes that land during a wait in execute.
// ----------------------------------------------------------------------------
module rv32_subset_single_cycle_core #(
   parameter int DATA_WORDS = rv32sc_pkg::DATA_WORDS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [31:0] csr_start_pc,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [31:0] req_instruction,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_next_pc,
   output logic             rsp_executed,
   output logic             rsp_branch_taken,
   output logic             rsp_reg_written,
   output logic [4:0]       rsp_dest_index,
   output logic [31:0]      rsp_dest_value,
   output logic             rsp_store_done,
   output logic [4:0]       rsp_store_word_index,
   output logic [31:0]      rsp_store_value
);
   import rv32sc_pkg::*;

   localparam int AW          = $clog2(DATA_WORDS);
   localparam int RMW         = $clog2(2 * DATA_WORDS);
   localparam int IDXW        = (AW > 5) ? AW : 5;
   localparam int CLEAR_WORDS = (DATA_WORDS > 32) ? DATA_WORDS : 32;
   localparam int CW          = $clog2(CLEAR_WORDS);
   localparam longint unsigned RECIP_L = (64'd1 << 32) / DATA_WORDS;
   localparam logic [30:0]     RECIP        = 31'(RECIP_L);
   localparam logic [29:0]     DATA_WORDS_W = 30'(DATA_WORDS);
   localparam logic [RMW-1:0]  DATA_WORDS_R = RMW'(DATA_WORDS);

   // ---------------- memories ----------------
   logic [31:0] rf_mem [32];
   logic [31:0] dm_mem [DATA_WORDS];
   logic [31:0] rf_rdata_ff [2];
   logic [31:0] dm_rdata_ff;

   // ---------------- clearing pass ----------------
   logic          clear_ff;
   logic [CW-1:0] clear_cnt_ff;

   // ---------------- pipe state ----------------
   logic [31:0] pc_reg_ff, pc_in;
   logic        d_valid_ff, a1_valid_ff, a2_valid_ff, m_valid_ff, w_valid_ff;
   logic [31:0] d_ins_ff;
   logic        d_fwd_valid_ff [2];
   logic [31:0] d_fwd_ff [2];
   logic        d_fwd_valid_in [2];
   logic [31:0] d_fwd_in [2];
   res_type     a1_res_ff, a2_res_ff, m_res_ff, w_res_ff;
   logic [29:0] a1_word_ff, a2_word_ff;
   logic [28:0] a2_quot_ff;
   logic [RMW-1:0] m_rem_ff;
   logic [4:0]  w_idx_ff;

   // ---------------- handshake / flow ----------------
   logic req_accept;
   logic w_free, m_go, m_free, a2_go, a2_free, a1_go, a1_free, d_go, d_free;
   logic hazard;

   // ---------------- execute ----------------
   logic [4:0]  d_rs [2];
   logic [31:0] d_base [2];
   logic [31:0] d_opnd [2];
   logic [6:0]  opcode, funct7;
   logic [2:0]  funct3;
   logic [4:0]  rd;
   logic [31:0] imm_i, imm_s, imm_b, alu_val, d_addr;
   logic        ex_exec, ex_wr, ex_load, ex_store, ex_taken;
   res_type     d_res;

   // ---------------- index path ----------------
   logic [60:0]    a1_prod;
   logic [29:0]    a2_rem;
   logic [RMW-1:0] m_idx_full;
   logic [AW-1:0]  m_idx;
   logic [IDXW-1:0] m_idx_wide;

   // ---------------- commit ----------------
   logic        commit;
   logic [31:0] w_value;
   logic        rf_we;
   logic [4:0]  rf_waddr;
   logic [31:0] rf_wdata;
   logic        dm_we;
   logic [AW-1:0] dm_waddr;
   logic [31:0] dm_wdata;

   assign csr_ready  = 1'b1;
   assign req_accept = req_valid && req_ready;

   assign w_free  = !w_valid_ff || rsp_ready;
   assign m_go    = m_valid_ff && w_free;
   assign m_free  = !m_valid_ff || w_free;
   assign a2_go   = a2_valid_ff && m_free;
   assign a2_free = !a2_valid_ff || m_free;
   assign a1_go   = a1_valid_ff && a2_free;
   assign a1_free = !a1_valid_ff || a2_free;
   assign d_go    = d_valid_ff && !hazard && a1_free;
   assign d_free  = !d_valid_ff || d_go;
   assign req_ready = !clear_ff && d_free;

   assign d_rs[0] = d_ins_ff[19:15];
   assign d_rs[1] = d_ins_ff[24:20];

   // load results are known only in the response stage
   always_comb begin
      hazard = 1'b0;
      for (int i = 0; i < 2; i++) begin
         if (d_rs[i] != 5'd0) begin
            if ((a1_valid_ff && a1_res_ff.is_load && a1_res_ff.dest_index == d_rs[i]) ||
                (a2_valid_ff && a2_res_ff.is_load && a2_res_ff.dest_index == d_rs[i]) ||
                (m_valid_ff && m_res_ff.is_load && m_res_ff.dest_index == d_rs[i])) begin
               hazard = 1'b1;
            end
         end
      end
   end

   assign w_value = w_res_ff.is_load ? dm_rdata_ff : w_res_ff.dest_value;
   assign commit  = w_valid_ff && rsp_ready && w_res_ff.reg_written;

   // operand select: youngest in-flight writer first, then RAM view
   always_comb begin
      for (int i = 0; i < 2; i++) begin
         d_base[i] = d_fwd_valid_ff[i] ? d_fwd_ff[i] : rf_rdata_ff[i];
         if (d_rs[i] == 5'd0) begin
            d_opnd[i] = 32'd0;
         end else if (a1_valid_ff && a1_res_ff.reg_written &&
                      a1_res_ff.dest_index == d_rs[i]) begin
            d_opnd[i] = a1_res_ff.dest_value;
         end else if (a2_valid_ff && a2_res_ff.reg_written &&
                      a2_res_ff.dest_index == d_rs[i]) begin
            d_opnd[i] = a2_res_ff.dest_value;
         end else if (m_valid_ff && m_res_ff.reg_written &&
                      m_res_ff.dest_index == d_rs[i]) begin
            d_opnd[i] = m_res_ff.dest_value;
         end else if (w_valid_ff && w_res_ff.reg_written &&
                      w_res_ff.dest_index == d_rs[i]) begin
            d_opnd[i] = w_value;
         end else begin
            d_opnd[i] = d_base[i];
         end
      end
   end

   // catch register file writes that land after the RAM read was taken
   always_comb begin
      for (int i = 0; i < 2; i++) begin
         d_fwd_valid_in[i] = d_fwd_valid_ff[i];
         d_fwd_in[i]       = d_fwd_ff[i];
         if (req_accept) begin
            d_fwd_valid_in[i] = commit && (w_res_ff.dest_index ==
                                (i == 0 ? req_instruction[19:15] : req_instruction[24:20]));
            d_fwd_in[i]       = w_value;
         end else if (commit && w_res_ff.dest_index == d_rs[i]) begin
            d_fwd_valid_in[i] = 1'b1;
            d_fwd_in[i]       = w_value;
         end
      end
   end

   assign opcode = d_ins_ff[6:0];
   assign rd     = d_ins_ff[11:7];
   assign funct3 = d_ins_ff[14:12];
   assign funct7 = d_ins_ff[31:25];
   assign imm_i  = {{20{d_ins_ff[31]}}, d_ins_ff[31:20]};
   assign imm_s  = {{20{d_ins_ff[31]}}, d_ins_ff[31:25], d_ins_ff[11:7]};
   assign imm_b  = {{19{d_ins_ff[31]}}, d_ins_ff[31], d_ins_ff[7],
                    d_ins_ff[30:25], d_ins_ff[11:8], 1'b0};

   always_comb begin
      ex_exec  = 1'b0;
      ex_wr    = 1'b0;
      ex_load  = 1'b0;
      ex_store = 1'b0;
      ex_taken = 1'b0;
      alu_val  = 32'd0;
      unique case (opcode)
         OPC_RTYPE: begin
            if (funct3 == F3_ADD && funct7 == F7_BASE) begin
               alu_val = d_opnd[0] + d_opnd[1];
               ex_exec = 1'b1;
            end else if (funct3 == F3_ADD && funct7 == F7_ALT) begin
               alu_val = d_opnd[0] - d_opnd[1];
               ex_exec = 1'b1;
            end else if (funct3 == F3_OR && funct7 == F7_BASE) begin
               alu_val = d_opnd[0] | d_opnd[1];
               ex_exec = 1'b1;
            end else if (funct3 == F3_AND && funct7 == F7_BASE) begin
               alu_val = d_opnd[0] & d_opnd[1];
               ex_exec = 1'b1;
            end
            ex_wr = ex_exec;
         end
         OPC_ITYPE: begin
            case (funct3)
               F3_ADD: begin
                  alu_val = d_opnd[0] + imm_i;
                  ex_exec = 1'b1;
               end
               F3_OR: begin
                  alu_val = d_opnd[0] | imm_i;
                  ex_exec = 1'b1;
               end
               F3_AND: begin
                  alu_val = d_opnd[0] & imm_i;
                  ex_exec = 1'b1;
               end
               default: ;
            endcase
            ex_wr = ex_exec;
         end
         OPC_LOAD: begin
            if (funct3 == F3_WORD) begin
               ex_exec = 1'b1;
               ex_wr   = 1'b1;
               ex_load = 1'b1;
            end
         end
         OPC_STORE: begin
            if (funct3 == F3_WORD) begin
               ex_exec  = 1'b1;
               ex_store = 1'b1;
            end
         end
         OPC_BRANCH: begin
            if (funct3 == F3_BEQ) begin
               ex_exec  = 1'b1;
               ex_taken = (d_opnd[0] == d_opnd[1]);
            end
         end
         default: ;
      endcase
   end

   assign d_addr = d_opnd[0] + (ex_store ? imm_s : imm_i);
   assign pc_in  = ex_taken ? pc_reg_ff + imm_b : pc_reg_ff + 32'd4;

   always_comb begin
      d_res              = '0;
      d_res.next_pc      = pc_in;
      d_res.executed     = ex_exec;
      d_res.branch_taken = ex_taken;
      d_res.reg_written  = ex_wr && (rd != 5'd0);
      d_res.dest_index   = d_res.reg_written ? rd : 5'd0;
      d_res.dest_value   = (d_res.reg_written && !ex_load) ? alu_val : 32'd0;
      d_res.is_load      = ex_load && d_res.reg_written;
      d_res.store_done   = ex_store;
      d_res.store_value  = ex_store ? d_opnd[1] : 32'd0;
   end

   // word index = (addr >> 2) mod DATA_WORDS by reciprocal, quotient off by at most one
   assign a1_prod = 61'(a1_word_ff) * 61'(RECIP);
   assign a2_rem  = a2_word_ff - 30'({1'b0, a2_quot_ff} * DATA_WORDS_W);

   always_comb begin
      if (m_rem_ff >= DATA_WORDS_R) begin
         m_idx_full = m_rem_ff - DATA_WORDS_R;
      end else begin
         m_idx_full = m_rem_ff;
      end
   end
   assign m_idx      = m_idx_full[AW-1:0];
   assign m_idx_wide = IDXW'(m_idx);

   // ---------------- write ports ----------------
   always_comb begin
      if (clear_ff) begin
         rf_we    = ({1'b0, clear_cnt_ff} < (CW + 1)'(32));
         rf_waddr = clear_cnt_ff[4:0];
         rf_wdata = 32'd0;
         dm_we    = ({1'b0, clear_cnt_ff} < (CW + 1)'(DATA_WORDS));
         dm_waddr = clear_cnt_ff[AW-1:0];
         dm_wdata = 32'd0;
      end else begin
         rf_we    = commit;
         rf_waddr = w_res_ff.dest_index;
         rf_wdata = w_value;
         dm_we    = m_go && m_res_ff.store_done;
         dm_waddr = m_idx;
         dm_wdata = m_res_ff.store_value;
      end
   end

   always_ff @(posedge clock) begin
      if (rf_we) begin
         rf_mem[rf_waddr] <= rf_wdata;
      end
      if (req_accept) begin
         rf_rdata_ff[0] <= rf_mem[req_instruction[19:15]];
         rf_rdata_ff[1] <= rf_mem[req_instruction[24:20]];
      end
   end

   always_ff @(posedge clock) begin
      if (dm_we) begin
         dm_mem[dm_waddr] <= dm_wdata;
      end
      if (m_go) begin
         dm_rdata_ff <= dm_mem[m_idx];
      end
   end

   // ---------------- control registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff     <= 1'b1;
         clear_cnt_ff <= '0;
         pc_reg_ff    <= 32'd0;
         d_valid_ff   <= 1'b0;
         a1_valid_ff  <= 1'b0;
         a2_valid_ff  <= 1'b0;
         m_valid_ff   <= 1'b0;
         w_valid_ff   <= 1'b0;
      end else begin
         if (clear_ff) begin
            clear_cnt_ff <= clear_cnt_ff + 1'b1;
            if (clear_cnt_ff == CW'(CLEAR_WORDS - 1)) begin
               clear_ff <= 1'b0;
            end
         end
         if (csr_valid && csr_ready) begin
            pc_reg_ff <= csr_start_pc;
         end else if (d_go) begin
            pc_reg_ff <= pc_in;
         end
         if (d_free) d_valid_ff <= req_accept;
         if (a1_free) a1_valid_ff <= d_go;
         if (a2_free) a2_valid_ff <= a1_go;
         if (m_free) m_valid_ff <= a2_go;
         if (w_free) w_valid_ff <= m_go;
      end
   end

   // ---------------- payload registers ----------------
   always_ff @(posedge clock) begin
      if (req_accept) begin
         d_ins_ff <= req_instruction;
      end
      for (int i = 0; i < 2; i++) begin
         d_fwd_valid_ff[i] <= d_fwd_valid_in[i];
         d_fwd_ff[i]       <= d_fwd_in[i];
      end
      if (d_go) begin
         a1_res_ff  <= d_res;
         a1_word_ff <= d_addr[31:2];
      end
      if (a1_go) begin
         a2_res_ff  <= a1_res_ff;
         a2_word_ff <= a1_word_ff;
         a2_quot_ff <= a1_prod[60:32];
      end
      if (a2_go) begin
         m_res_ff <= a2_res_ff;
         m_rem_ff <= a2_rem[RMW-1:0];
      end
      if (m_go) begin
         w_res_ff <= m_res_ff;
         w_idx_ff <= m_res_ff.store_done ? m_idx_wide[4:0] : 5'd0;
      end
   end

   // ---------------- response ----------------
   assign rsp_valid            = w_valid_ff;
   assign rsp_next_pc          = w_res_ff.next_pc;
   assign rsp_executed         = w_res_ff.executed;
   assign rsp_branch_taken     = w_res_ff.branch_taken;
   assign rsp_reg_written      = w_res_ff.reg_written;
   assign rsp_dest_index       = w_res_ff.dest_index;
   assign rsp_dest_value       = w_value;
   assign rsp_store_done       = w_res_ff.store_done;
   assign rsp_store_word_index = w_idx_ff;
   assign rsp_store_value      = w_res_ff.store_value;

endmodule
`default_nettype wire
